// File: rtl/bdmd_pkg.sv
// ----------------------------------------------------------------------------
// bdmd_pkg
// Types, widths and constants shared by the baseline deviation metal detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bdmd_pkg;

  // Field widths
  localparam int KIND_W   = 3;
  localparam int MAG_W    = 20;
  localparam int ROCK_W   = 8;
  localparam int PHASE_W  = 3;
  localparam int SETTLE_W = 16;
  localparam int THRESH_W = 20;

  localparam longint unsigned MAG_MAX = (64'd1 << MAG_W) - 64'd1;

  // Averaging counts
  localparam int BASELINE_SAMPLES = 20;
  localparam int CHECK_SAMPLES    = 6;

  localparam int BASE_CNT_W  = $clog2(BASELINE_SAMPLES + 1);
  localparam int CHECK_CNT_W = $clog2(CHECK_SAMPLES + 1);
  localparam int BASE_SUM_W  = $clog2(64'(BASELINE_SAMPLES) * MAG_MAX + 64'd1);
  localparam int CHECK_SUM_W = $clog2(64'(CHECK_SAMPLES) * MAG_MAX + 64'd1);

  localparam logic [BASE_CNT_W-1:0]  BASE_CNT_DONE  = BASE_CNT_W'(BASELINE_SAMPLES);
  localparam logic [CHECK_CNT_W-1:0] CHECK_CNT_DONE = CHECK_CNT_W'(CHECK_SAMPLES);

  // Division by a constant count: floor(x / D) == (x * ceil(2^S / D)) >> S holds
  // exactly for every x below 2^N when S = N + clog2(D).
  localparam int BASE_SHIFT = BASE_SUM_W + $clog2(BASELINE_SAMPLES);
  localparam longint unsigned BASE_RECIP_VAL =
    ((64'd1 << BASE_SHIFT) + 64'(BASELINE_SAMPLES) - 64'd1) / 64'(BASELINE_SAMPLES);
  localparam int BASE_RECIP_W = $clog2(BASE_RECIP_VAL + 64'd1);
  localparam logic [BASE_RECIP_W-1:0] BASE_RECIP = BASE_RECIP_W'(BASE_RECIP_VAL);
  localparam int BASE_PROD_W = BASE_SUM_W + BASE_RECIP_W;

  localparam int CHECK_SHIFT = CHECK_SUM_W + $clog2(CHECK_SAMPLES);
  localparam longint unsigned CHECK_RECIP_VAL =
    ((64'd1 << CHECK_SHIFT) + 64'(CHECK_SAMPLES) - 64'd1) / 64'(CHECK_SAMPLES);
  localparam int CHECK_RECIP_W = $clog2(CHECK_RECIP_VAL + 64'd1);
  localparam logic [CHECK_RECIP_W-1:0] CHECK_RECIP = CHECK_RECIP_W'(CHECK_RECIP_VAL);
  localparam int CHECK_PROD_W = CHECK_SUM_W + CHECK_RECIP_W;

  localparam logic [SETTLE_W-1:0] ELAPSED_MAX = '1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BASELINE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR_BASE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK        = 3'd5;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_SETTLING = 3'd1,
    PH_SAMPLING = 3'd2,
    PH_FINISHED = 3'd3,
    PH_FAILED   = 3'd4
  } phase_t;

  // Configuration port
  localparam int ADDR_W   = 3;
  localparam int ADDR_LSB = 2;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = ADDR_W - ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DEV_THRESH   = 1'b1;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd2000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd2400;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [THRESH_W-1:0] deviation_threshold;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MAG_W-1:0]  magnitude_zero;
    logic [MAG_W-1:0]  magnitude_one;
    logic [ROCK_W-1:0] rock_index;
    logic              coil_select;
  } in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               baselines_ready;
    logic               metal_found;
    logic [MAG_W-1:0]   check_average;
    logic [MAG_W-1:0]   reference_average;
    logic [MAG_W-1:0]   deviation;
    logic [ROCK_W-1:0]  checked_rock;
    logic               checked_coil;
    logic [MAG_W-1:0]   baseline_zero;
    logic [MAG_W-1:0]   baseline_one;
  } out_t;

  typedef struct packed {
    phase_t                 phase;
    logic [BASE_SUM_W-1:0]  base_sum_zero;
    logic [BASE_SUM_W-1:0]  base_sum_one;
    logic [MAG_W-1:0]       base_avg_zero;
    logic [MAG_W-1:0]       base_avg_one;
    logic [BASE_CNT_W-1:0]  base_count;
    logic                   ready_flag;
    logic [CHECK_SUM_W-1:0] check_sum;
    logic [CHECK_CNT_W-1:0] check_count;
    logic [SETTLE_W-1:0]    elapsed_ticks;
    logic [ROCK_W-1:0]      active_rock;
    logic                   active_coil;
    logic [MAG_W-1:0]       last_check_avg;
    logic [MAG_W-1:0]       last_reference;
    logic [MAG_W-1:0]       last_deviation;
    logic [ROCK_W-1:0]      last_rock;
    logic                   last_coil;
    logic                   last_metal;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bdmd_in_if.sv
// ----------------------------------------------------------------------------
// bdmd_in_if
// Valid/ready channel that carries one detector item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdmd_in_if;
  logic           valid;
  logic           ready;
  bdmd_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bdmd_out_if.sv
// ----------------------------------------------------------------------------
// bdmd_out_if
// Valid/ready channel that carries one detector status result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdmd_out_if;
  logic           valid;
  logic           ready;
  bdmd_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bdmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdmd_cfg_regs
// APB-style register file for the settle time and the deviation threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmd_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bdmd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bdmd_pkg::DATA_W-1:0]   pwdata,
  output logic      [bdmd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output bdmd_pkg::cfg_t                     cfg
);

  logic [bdmd_pkg::SETTLE_W-1:0]  settle_ticks_r, settle_ticks_nxt;
  logic [bdmd_pkg::THRESH_W-1:0]  dev_thresh_r, dev_thresh_nxt;
  logic [bdmd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bdmd_pkg::ADDR_W-1:bdmd_pkg::ADDR_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    settle_ticks_nxt = settle_ticks_r;
    dev_thresh_nxt   = dev_thresh_r;
    if (wr_en) begin
      unique case (reg_idx)
        bdmd_pkg::REG_SETTLE_TICKS: settle_ticks_nxt = pwdata[bdmd_pkg::SETTLE_W-1:0];
        bdmd_pkg::REG_DEV_THRESH:   dev_thresh_nxt   = pwdata[bdmd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdmd_pkg::REG_SETTLE_TICKS: prdata = bdmd_pkg::DATA_W'(settle_ticks_r);
      bdmd_pkg::REG_DEV_THRESH:   prdata = bdmd_pkg::DATA_W'(dev_thresh_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= bdmd_pkg::SETTLE_RESET;
      dev_thresh_r   <= bdmd_pkg::THRESH_RESET;
    end else begin
      settle_ticks_r <= settle_ticks_nxt;
      dev_thresh_r   <= dev_thresh_nxt;
    end
  end

  assign cfg.settle_ticks        = settle_ticks_r;
  assign cfg.deviation_threshold = dev_thresh_r;

endmodule

`default_nettype wire

// File: rtl/bdmd_step.sv
// ----------------------------------------------------------------------------
// bdmd_step
// Next-state and result logic for one detector item.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmd_step (
  input  wire bdmd_pkg::state_t st,
  input  wire bdmd_pkg::in_t    item,
  input  wire bdmd_pkg::cfg_t   cfg,
  output bdmd_pkg::state_t      st_nxt,
  output bdmd_pkg::out_t        res
);

  logic [bdmd_pkg::BASE_SUM_W-1:0]   base_sum_zero_add;
  logic [bdmd_pkg::BASE_SUM_W-1:0]   base_sum_one_add;
  logic [bdmd_pkg::BASE_CNT_W-1:0]   base_cnt_inc;
  logic [bdmd_pkg::BASE_PROD_W-1:0]  base_prod_zero;
  logic [bdmd_pkg::BASE_PROD_W-1:0]  base_prod_one;
  logic [bdmd_pkg::MAG_W-1:0]        check_sample;
  logic [bdmd_pkg::CHECK_SUM_W-1:0]  check_sum_add;
  logic [bdmd_pkg::CHECK_CNT_W-1:0]  check_cnt_inc;
  logic [bdmd_pkg::CHECK_PROD_W-1:0] check_prod;
  logic [bdmd_pkg::MAG_W-1:0]        check_avg;
  logic [bdmd_pkg::MAG_W-1:0]        ref_avg;
  logic [bdmd_pkg::MAG_W-1:0]        dev;

  assign base_sum_zero_add = st.base_sum_zero
                           + bdmd_pkg::BASE_SUM_W'(item.magnitude_zero);
  assign base_sum_one_add  = st.base_sum_one
                           + bdmd_pkg::BASE_SUM_W'(item.magnitude_one);
  assign base_cnt_inc      = st.base_count + 1'b1;

  // Truncating averages through a reciprocal multiply.
  assign base_prod_zero = bdmd_pkg::BASE_PROD_W'(base_sum_zero_add)
                        * bdmd_pkg::BASE_PROD_W'(bdmd_pkg::BASE_RECIP);
  assign base_prod_one  = bdmd_pkg::BASE_PROD_W'(base_sum_one_add)
                        * bdmd_pkg::BASE_PROD_W'(bdmd_pkg::BASE_RECIP);

  // Coil 0 faces detector 1, coil 1 faces detector 0.
  assign check_sample  = st.active_coil ? item.magnitude_zero : item.magnitude_one;
  assign check_sum_add = st.check_sum + bdmd_pkg::CHECK_SUM_W'(check_sample);
  assign check_cnt_inc = st.check_count + 1'b1;
  assign check_prod    = bdmd_pkg::CHECK_PROD_W'(check_sum_add)
                       * bdmd_pkg::CHECK_PROD_W'(bdmd_pkg::CHECK_RECIP);
  assign check_avg     = check_prod[bdmd_pkg::CHECK_SHIFT +: bdmd_pkg::MAG_W];
  assign ref_avg       = st.active_coil ? st.base_avg_zero : st.base_avg_one;
  assign dev           = (check_avg >= ref_avg) ? (check_avg - ref_avg)
                                                : (ref_avg - check_avg);

  always_comb begin
    st_nxt = st;
    unique case (item.kind)
      bdmd_pkg::KIND_BASELINE: begin
        if (!st.ready_flag) begin
          st_nxt.base_sum_zero = base_sum_zero_add;
          st_nxt.base_sum_one  = base_sum_one_add;
          st_nxt.base_count    = base_cnt_inc;
          if (base_cnt_inc >= bdmd_pkg::BASE_CNT_DONE) begin
            st_nxt.base_avg_zero = base_prod_zero[bdmd_pkg::BASE_SHIFT +: bdmd_pkg::MAG_W];
            st_nxt.base_avg_one  = base_prod_one[bdmd_pkg::BASE_SHIFT +: bdmd_pkg::MAG_W];
            st_nxt.ready_flag    = 1'b1;
          end
        end
      end
      bdmd_pkg::KIND_CHECK: begin
        if (st.phase == bdmd_pkg::PH_SETTLING) begin
          if (st.elapsed_ticks >= cfg.settle_ticks) begin
            st_nxt.phase = bdmd_pkg::PH_SAMPLING;
          end
        end else if (st.phase == bdmd_pkg::PH_SAMPLING) begin
          st_nxt.check_sum   = check_sum_add;
          st_nxt.check_count = check_cnt_inc;
          if (check_cnt_inc >= bdmd_pkg::CHECK_CNT_DONE) begin
            st_nxt.last_check_avg = check_avg;
            st_nxt.last_reference = ref_avg;
            st_nxt.last_deviation = dev;
            st_nxt.last_metal     = (dev >= cfg.deviation_threshold);
            st_nxt.last_rock      = st.active_rock;
            st_nxt.last_coil      = st.active_coil;
            st_nxt.phase          = bdmd_pkg::PH_FINISHED;
          end
        end
      end
      bdmd_pkg::KIND_START: begin
        if (!st.ready_flag) begin
          st_nxt.phase = bdmd_pkg::PH_FAILED;
        end else begin
          st_nxt.active_rock   = item.rock_index;
          st_nxt.active_coil   = item.coil_select;
          st_nxt.check_sum     = '0;
          st_nxt.check_count   = '0;
          st_nxt.last_metal    = 1'b0;
          st_nxt.elapsed_ticks = '0;
          st_nxt.phase         = bdmd_pkg::PH_SETTLING;
        end
      end
      bdmd_pkg::KIND_STOP: begin
        st_nxt.phase = bdmd_pkg::PH_IDLE;
      end
      bdmd_pkg::KIND_CLEAR_BASE: begin
        st_nxt.base_sum_zero  = '0;
        st_nxt.base_sum_one   = '0;
        st_nxt.base_avg_zero  = '0;
        st_nxt.base_avg_one   = '0;
        st_nxt.base_count     = '0;
        st_nxt.ready_flag     = 1'b0;
        st_nxt.last_check_avg = '0;
        st_nxt.last_reference = '0;
        st_nxt.last_deviation = '0;
        st_nxt.last_rock      = '0;
        st_nxt.last_coil      = 1'b0;
        st_nxt.last_metal     = 1'b0;
        st_nxt.phase          = bdmd_pkg::PH_IDLE;
      end
      bdmd_pkg::KIND_TICK: begin
        if (st.elapsed_ticks != bdmd_pkg::ELAPSED_MAX) begin
          st_nxt.elapsed_ticks = st.elapsed_ticks + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The result shows the state after the item.
  always_comb begin
    res.phase             = st_nxt.phase;
    res.baselines_ready   = st_nxt.ready_flag;
    res.metal_found       = st_nxt.last_metal;
    res.check_average     = st_nxt.last_check_avg;
    res.reference_average = st_nxt.last_reference;
    res.deviation         = st_nxt.last_deviation;
    res.checked_rock      = st_nxt.last_rock;
    res.checked_coil      = st_nxt.last_coil;
    res.baseline_zero     = st_nxt.base_avg_zero;
    res.baseline_one      = st_nxt.base_avg_one;
  end

endmodule

`default_nettype wire

// File: rtl/baseline_deviation_metal_detector_core.sv
// ----------------------------------------------------------------------------
// baseline_deviation_metal_detector_core
// Two-coil metal detector qualifier with baseline averaging and a
// thresholded deviation check.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (baseline samples, check updates, start, stop,
// baseline clear and millisecond ticks). Every item yields exactly one
// status transaction on out_ch that shows the detector state after it.
// The settle time and the deviation threshold are to be written through the
// APB-style port while no item is in flight; the block does not enforce it.
//
// An accepted item lands in an input register; once the output register is
// free or being emptied, the state update, the constant-count average, the
// deviation and the threshold compare are done in one pass and the status
// is captured in the output register. One item is taken per cycle while the
// receiver does not stall; the per-item state update is the only loop.
//
// Reset clears the detector state and loads the default settle time (2000
// ticks) and threshold (2400); no clearing pass is needed.
// While the receiver stalls, the status and the item behind it are held and
// in_ch.ready drops once both registers are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module baseline_deviation_metal_detector_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bdmd_in_if.sink                          in_ch,
  bdmd_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bdmd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bdmd_pkg::DATA_W-1:0] pwdata,
  output logic      [bdmd_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  bdmd_pkg::cfg_t   cfg;
  bdmd_pkg::state_t st_r, st_nxt;
  bdmd_pkg::in_t    in_data_r;
  bdmd_pkg::out_t   out_data_r, res;
  logic             in_valid_r, in_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  logic             in_take;

  bdmd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdmd_step u_step (
    .st     (st_r),
    .item   (in_data_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // The held item moves on when the output register is free or being emptied.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_ch.data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A completed item always produces a status transaction.
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item did not produce a status transaction");

  // Baselines lock only after the full sample count.
  a_lock_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.ready_flag) |-> (st_r.base_count == bdmd_pkg::BASE_CNT_DONE))
    else $error("baselines locked before the sample count was reached");

  // A running or finished check implies locked baselines.
  a_check_needs_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == bdmd_pkg::PH_SETTLING || st_r.phase == bdmd_pkg::PH_SAMPLING ||
     st_r.phase == bdmd_pkg::PH_FINISHED) |-> st_r.ready_flag)
    else $error("check phase active without locked baselines");

  // While sampling, fewer than the full count of check samples are summed.
  a_sampling_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == bdmd_pkg::PH_SAMPLING) |-> (st_r.check_count < bdmd_pkg::CHECK_CNT_DONE))
    else $error("check sample count overran while sampling");

  // Unlocked baselines read as zero.
  a_unlocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.ready_flag |-> (st_r.base_avg_zero == '0 && st_r.base_avg_one == '0))
    else $error("baseline average nonzero while unlocked");

endmodule

`default_nettype wire
